### rtl/dmst_pkg.sv
// dmst_pkg: shared types and constants for the direct-mapped search table
// request, response and table entry structs, request/bound codes, controller interface
// no dependencies
`default_nettype none

package dmst_pkg;

    // request codes
    localparam logic [1:0] REQ_PROBE = 2'd0;
    localparam logic [1:0] REQ_STORE = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    // bound codes
    localparam logic [1:0] BOUND_ALL = 2'd0;
    localparam logic [1:0] BOUND_PV  = 2'd2;

    // depth value of an empty slot and of a miss
    localparam logic signed [7:0] DEPTH_NONE = -8'sd1;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [63:0]        key;
        logic signed [7:0]  search_depth;
        logic signed [15:0] eval_score;
        logic [1:0]         bound_kind;
        logic [31:0]        move_code;
    } req_t;

    typedef struct packed {
        logic               hit;
        logic signed [15:0] out_score;
        logic signed [7:0]  out_depth;
        logic [1:0]         out_bound;
        logic [31:0]        out_move;
    } rsp_t;

    typedef struct packed {
        logic [63:0]        key;
        logic signed [15:0] score;
        logic signed [7:0]  depth;
        logic [1:0]         bound;
        logic [31:0]        move;
    } entry_t;

    // controller to datapath
    typedef struct packed {
        logic capture;      // latch request, read its slot
        logic evaluate;     // compare read slot, maybe write, answer
        logic miss;         // answer an unused request code
        logic sweep_begin;  // latch clear move value
        logic sweep_write;  // clear one slot, advance index
        logic report_clear; // answer the clear request
    } dmst_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic sweep_last;
    } dmst_sts_t;

endpackage

`default_nettype wire

### rtl/direct_mapped_search_table.sv
// direct_mapped_search_table: top level of the direct-mapped search result table
// joins the controller dmst_ctrl and the datapath dmst_datapath
// depends on dmst_pkg
// probe and store: request and slot are registered on acceptance, the lookup state then answers; busy is high in lookup
// clear: busy while the sweep clears one slot per cycle, result strobe in the cycle after the last slot
// unused request code: miss result in the next cycle, no busy time
// after reset the table is swept with busy high and no result
// results last one cycle on done and cannot be stalled by the receiver
`default_nettype none

module direct_mapped_search_table
    import dmst_pkg::*;
#(
    parameter int TABLE_ENTRIES = 1024
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // request transaction
    input  wire logic        start,
    output logic             busy,
    input  wire req_t        req,
    // result transaction
    output logic             done,
    output rsp_t             rsp,
    // empty-move register
    input  wire logic        cfg_we,
    input  wire logic [31:0] cfg_wdata
);

    dmst_cmd_t cmd;
    dmst_sts_t sts;

    // state machine: idle, lookup, clearing sweep
    dmst_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req.req_type),
        .sts      (sts),
        .cmd      (cmd),
        .busy     (busy)
    );

    // memory, replacement decision and result register
    dmst_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .sts       (sts),
        .done      (done),
        .rsp       (rsp)
    );

    // every result follows a cycle of work or an accepted transaction
    a_done_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy) || $past(start))
        else $error("result strobe without a transaction");

endmodule

`default_nettype wire

### rtl/dmst_ctrl.sv
// dmst_ctrl: controller state machine of the direct-mapped search table
// sequences lookup and clearing sweep, issues commands to dmst_datapath
// depends on dmst_pkg
`default_nettype none

module dmst_ctrl
    import dmst_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    input  wire logic [1:0] req_type,
    input  wire dmst_sts_t sts,
    output dmst_cmd_t      cmd,
    output logic           busy
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_LOOKUP = 2'd1;
    localparam logic [1:0] ST_SWEEP  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       report_reg;
    logic       report_next;
    logic       accept;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    always_comb
    begin
        state_next  = state_reg;
        report_next = report_reg;
        cmd         = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (req_type) inside
                        REQ_PROBE, REQ_STORE:
                        begin
                            cmd.capture = 1'b1;
                            state_next  = ST_LOOKUP;
                        end
                        REQ_CLEAR:
                        begin
                            cmd.sweep_begin = 1'b1;
                            report_next     = 1'b1;
                            state_next      = ST_SWEEP;
                        end
                        default:
                        begin
                            cmd.miss = 1'b1;
                        end
                    endcase
                end
            end
            ST_LOOKUP:
            begin
                cmd.evaluate = 1'b1;
                state_next   = ST_IDLE;
            end
            ST_SWEEP:
            begin
                cmd.sweep_write = 1'b1;
                if (sts.sweep_last)
                begin
                    cmd.report_clear = report_reg;
                    report_next      = 1'b0;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // reset starts with a silent clearing sweep
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_SWEEP;
            report_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            report_reg <= report_next;
        end
    end

    a_lookup_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_LOOKUP |=> state_reg == ST_IDLE)
        else $error("lookup state lasted more than one cycle");

    a_lookup_after_capture: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_LOOKUP |-> $past(cmd.capture))
        else $error("lookup without a captured request");

    a_single_command: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.capture, cmd.evaluate, cmd.miss, cmd.sweep_begin, cmd.sweep_write}))
        else $error("conflicting datapath commands");

endmodule

`default_nettype wire

### rtl/dmst_datapath.sv
// dmst_datapath: table memory, slot compare, replacement decision and result register
// also holds the empty-move configuration register and the sweep index
// depends on dmst_pkg
`default_nettype none

module dmst_datapath
    import dmst_pkg::*;
#(
    parameter int TABLE_ENTRIES = 1024
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire req_t        req,
    input  wire logic        cfg_we,
    input  wire logic [31:0] cfg_wdata,
    input  wire dmst_cmd_t   cmd,
    output dmst_sts_t        sts,
    output logic             done,
    output rsp_t             rsp
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] IDX_MASK = IDX_W'(TABLE_ENTRIES - 1);

    entry_t mem [TABLE_ENTRIES];

    req_t             req_reg;
    entry_t           rd_reg;
    logic [31:0]      empty_move_reg;
    logic [31:0]      clear_move_reg;
    logic [IDX_W-1:0] sweep_idx_reg;
    logic [IDX_W-1:0] sweep_idx_next;
    logic             done_reg;
    logic             done_next;
    rsp_t             rsp_reg;
    rsp_t             rsp_next;

    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] store_addr;
    logic             probe_hit;
    logic             store_ok;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;
    entry_t           cleared;
    rsp_t             miss_rsp;

    assign rd_addr    = req.key[IDX_W-1:0] & IDX_MASK;
    assign store_addr = req_reg.key[IDX_W-1:0] & IDX_MASK;

    assign probe_hit = (req_reg.key != 64'd0) && (rd_reg.key == req_reg.key);
    assign store_ok  = (req_reg.key != 64'd0)
                    && ((rd_reg.key == 64'd0) || (rd_reg.key == req_reg.key)
                        || (req_reg.search_depth > rd_reg.depth)
                        || (req_reg.bound_kind == BOUND_PV));

    assign cleared.key   = 64'd0;
    assign cleared.score = 16'sd0;
    assign cleared.depth = DEPTH_NONE;
    assign cleared.bound = BOUND_ALL;
    assign cleared.move  = clear_move_reg;

    assign miss_rsp.hit       = 1'b0;
    assign miss_rsp.out_score = 16'sd0;
    assign miss_rsp.out_depth = DEPTH_NONE;
    assign miss_rsp.out_bound = 2'd0;
    assign miss_rsp.out_move  = 32'd0;

    assign sts.sweep_last = (sweep_idx_reg == IDX_MASK);

    always_comb
    begin
        wr_en          = 1'b0;
        wr_addr        = store_addr;
        wr_data        = cleared;
        sweep_idx_next = sweep_idx_reg;
        if (cmd.sweep_write)
        begin
            wr_en   = 1'b1;
            wr_addr = sweep_idx_reg;
            sweep_idx_next = sts.sweep_last ? '0 : sweep_idx_reg + 1'b1;
        end
        else if (cmd.evaluate && req_reg.req_type == REQ_STORE && store_ok)
        begin
            wr_en         = 1'b1;
            wr_data.key   = req_reg.key;
            wr_data.score = req_reg.eval_score;
            wr_data.depth = req_reg.search_depth;
            wr_data.bound = req_reg.bound_kind;
            wr_data.move  = req_reg.move_code;
        end
    end

    always_comb
    begin
        done_next = cmd.evaluate || cmd.miss || cmd.report_clear;
        rsp_next  = miss_rsp;
        if (cmd.evaluate)
        begin
            if (req_reg.req_type == REQ_PROBE)
            begin
                if (probe_hit)
                begin
                    rsp_next.hit       = 1'b1;
                    rsp_next.out_score = rd_reg.score;
                    rsp_next.out_depth = rd_reg.depth;
                    rsp_next.out_bound = rd_reg.bound;
                    rsp_next.out_move  = rd_reg.move;
                end
            end
            else
            begin
                rsp_next.hit = store_ok;
            end
        end
        else if (cmd.report_clear)
        begin
            rsp_next.hit = 1'b1;
        end
    end

    // table memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.capture)
        begin
            rd_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg <= req;
        end
        rsp_reg <= rsp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            empty_move_reg <= 32'd0;
            clear_move_reg <= 32'd0;
            sweep_idx_reg  <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                empty_move_reg <= cfg_wdata;
            end
            if (cmd.sweep_begin)
            begin
                clear_move_reg <= empty_move_reg;
            end
            sweep_idx_reg <= sweep_idx_next;
            done_reg      <= done_next;
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

    a_sweep_from_zero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sweep_begin |-> sweep_idx_reg == '0)
        else $error("clearing sweep does not start at slot zero");

    a_no_write_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
        done && !rsp.hit |-> $past(!wr_en))
        else $error("table written on a miss result");

endmodule

`default_nettype wire

### test/tb_top.sv
// tb_top: self-checking testbench for direct_mapped_search_table
// drives probe, store, clear and unused-code transactions, predicts every response
// from its own copy of the table or takes a hand-written one, and compares each field on the done strobe
// depends on dmst_pkg and the direct_mapped_search_table rtl
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import dmst_pkg::*;

    // table size used for the instance and for the predictor
    localparam int SLOTS        = 1024;
    localparam int SLOT_W       = $clog2(SLOTS);
    // generous ceiling: ~650 transactions with gaps plus a dozen full clear sweeps
    localparam int CYCLE_LIMIT  = 400000;
    // cap on printed mismatch lines, counting goes on past it
    localparam int PRINT_CAP    = 40;

    // codes the package leaves out
    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam logic [1:0] BOUND_CUT  = 2'd1;
    localparam logic [1:0] BOUND_BAD  = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    req_t        req;
    logic        done;
    rsp_t        rsp;
    logic        cfg_we;
    logic [31:0] cfg_wdata;

    // directed stimulus row: request plus an optional hand-written response
    typedef struct {
        req_t rq;
        bit   has_want;
        rsp_t want;
    } dir_row_t;

    dir_row_t dir_rows[$];

    // predictor state: shadow table and shadow empty-move register
    entry_t      slot_mem [SLOTS];
    logic [31:0] empty_move_q;

    // responses still owed by the dut, oldest first
    rsp_t        owed_rsp_q[$];

    // keys recently stored, reused so probes hit and stores collide
    logic [63:0] key_pool[$];

    // sender burst state
    int          burst_left;

    // bookkeeping
    int          n_fail;
    int          n_req;
    int          n_probe_hits;
    int          n_writes;
    int          n_clears;
    int          n_unused;
    int          n_cycles;

    direct_mapped_search_table #(
        .TABLE_ENTRIES(SLOTS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic req_t mk_req(input logic [1:0] kind, input logic [63:0] key,
                                    input logic signed [7:0] depth,
                                    input logic signed [15:0] score,
                                    input logic [1:0] bound, input logic [31:0] move);
        req_t r;
        r.req_type     = kind;
        r.key          = key;
        r.search_depth = depth;
        r.eval_score   = score;
        r.bound_kind   = bound;
        r.move_code    = move;
        return r;
    endfunction

    function automatic rsp_t mk_rsp(input logic hit, input logic signed [15:0] score,
                                    input logic signed [7:0] depth,
                                    input logic [1:0] bound, input logic [31:0] move);
        rsp_t r;
        r.hit       = hit;
        r.out_score = score;
        r.out_depth = depth;
        r.out_bound = bound;
        r.out_move  = move;
        return r;
    endfunction

    function automatic void add_row(input req_t rq, input bit has_want, input rsp_t want);
        dir_row_t row;
        row.rq       = rq;
        row.has_want = has_want;
        row.want     = want;
        dir_rows.push_back(row);
    endfunction

    // every slot back to empty, move taken from the shadow register
    function automatic void wipe_table();
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_mem[i].key   = '0;
            slot_mem[i].score = '0;
            slot_mem[i].depth = DEPTH_NONE;
            slot_mem[i].bound = BOUND_ALL;
            slot_mem[i].move  = empty_move_q;
        end
    endfunction

    // apply one request to the shadow table and return the response it owes
    function automatic rsp_t table_access(input req_t rq);
        logic [SLOT_W-1:0] idx;
        rsp_t              r;
        logic              replace;
        idx = rq.key[SLOT_W-1:0];
        // miss values are the default for every field
        r = mk_rsp(1'b0, '0, DEPTH_NONE, BOUND_ALL, '0);
        case (rq.req_type)
            REQ_PROBE:
            begin
                // key zero never hits, even against an empty slot
                if (rq.key != '0 && slot_mem[idx].key == rq.key)
                begin
                    r = mk_rsp(1'b1, slot_mem[idx].score, slot_mem[idx].depth,
                               slot_mem[idx].bound, slot_mem[idx].move);
                    n_probe_hits++;
                end
            end
            REQ_STORE:
            begin
                // replacement: empty slot, same key, deeper search, or exact bound
                replace = slot_mem[idx].key == '0 || slot_mem[idx].key == rq.key ||
                          $signed(rq.search_depth) > $signed(slot_mem[idx].depth) ||
                          rq.bound_kind == BOUND_PV;
                if (rq.key != '0 && replace)
                begin
                    slot_mem[idx].key   = rq.key;
                    slot_mem[idx].score = rq.eval_score;
                    slot_mem[idx].depth = rq.search_depth;
                    slot_mem[idx].bound = rq.bound_kind;
                    slot_mem[idx].move  = rq.move_code;
                    r.hit = 1'b1;
                    n_writes++;
                end
            end
            REQ_CLEAR:
            begin
                wipe_table();
                r.hit = 1'b1;
                n_clears++;
            end
            default:
            begin
                // unused request code: nothing changes, plain miss
                n_unused++;
            end
        endcase
        return r;
    endfunction

    // key selection for random traffic: mostly recent keys, some slot collisions,
    // some zero keys, the rest fully random
    function automatic logic [63:0] pick_key();
        int          roll;
        logic [63:0] k;
        roll = $urandom_range(0, 99);
        if (key_pool.size() != 0 && roll < 55)
            k = key_pool[$urandom_range(0, key_pool.size() - 1)];
        else if (key_pool.size() != 0 && roll < 75)
        begin
            // same slot, different upper bits
            k = {$urandom, $urandom};
            k[9:0] = key_pool[$urandom_range(0, key_pool.size() - 1)][9:0];
        end
        else if (roll < 80)
            k = '0;
        else
            k = {$urandom, $urandom};
        return k;
    endfunction

    function automatic req_t random_req();
        int   roll;
        req_t r;
        roll = $urandom_range(0, 999);
        r = mk_req(REQ_PROBE, pick_key(), 8'($urandom), 16'($urandom),
                   2'($urandom_range(0, 3)), $urandom);
        if (roll < 12)
            r.req_type = REQ_CLEAR;
        else if (roll < 30)
            r.req_type = REQ_UNUSED;
        else if (roll >= 480)
        begin
            r.req_type = REQ_STORE;
            if (r.key != '0)
            begin
                key_pool.push_back(r.key);
                if (key_pool.size() > 48)
                    void'(key_pool.pop_front());
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (n_fail < PRINT_CAP)
            $display("[%0t] mismatch %s: got %0h want %0h", $realtime, what, got, want);
        n_fail++;
    endtask

    // write the empty-move register; only called with the dut idle
    task automatic write_empty_move(input logic [31:0] value);
        cfg_wdata <= value;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we    <= 1'b0;
        empty_move_q = value;
    endtask

    // one request transaction; the sender sometimes idles between bursts of random length.
    // start is left high on return so back-to-back items need no extra edge
    task automatic send_req(input req_t rq, input bit has_want, input rsp_t want);
        rsp_t pred;
        int   gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            // now and then a long burst with no idling at all
            burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 6);
        end
        burst_left--;
        start <= 1'b1;
        req   <= rq;
        // accepted at the first edge with busy low (pre-edge values)
        do
            @(posedge clk);
        while (busy);
        n_req++;
        pred = table_access(rq);
        owed_rsp_q.push_back(has_want ? want : pred);
    endtask

    // wait for every owed response, then a short settle
    task automatic drain();
        while (owed_rsp_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // response checker: done marks a one-cycle response that cannot be held off
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && done === 1'b1)
        begin
            if (owed_rsp_q.size() == 0)
                report_mismatch("unexpected response, hit", 64'(rsp.hit), '0);
            else
            begin
                want = owed_rsp_q.pop_front();
                if (rsp.hit !== want.hit)
                    report_mismatch("hit", 64'(rsp.hit), 64'(want.hit));
                if (rsp.out_score !== want.out_score)
                    report_mismatch("out_score", 64'(rsp.out_score), 64'(want.out_score));
                if (rsp.out_depth !== want.out_depth)
                    report_mismatch("out_depth", 64'(rsp.out_depth), 64'(want.out_depth));
                if (rsp.out_bound !== want.out_bound)
                    report_mismatch("out_bound", 64'(rsp.out_bound), 64'(want.out_bound));
                if (rsp.out_move !== want.out_move)
                    report_mismatch("out_move", 64'(rsp.out_move), 64'(want.out_move));
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT)
        begin
            $display("direct_mapped_search_table test failed");
            $finish;
        end
    end

    initial
    begin
        rsp_t miss_rsp;
        rsp_t wrote_rsp;
        // two keys sharing slot 5, plus keys at the index extremes
        logic [63:0] key_a;
        logic [63:0] key_b;
        logic [63:0] key_max;
        logic [63:0] key_top;

        rst_n        = 1'b0;
        start        = 1'b0;
        req          = '0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        n_fail       = 0;
        n_req        = 0;
        n_probe_hits = 0;
        n_writes     = 0;
        n_clears     = 0;
        n_unused     = 0;
        n_cycles     = 0;
        burst_left   = 0;
        empty_move_q = '0;
        wipe_table();

        key_a   = 64'h0123_4567_89AB_C005;
        key_b   = 64'hFEDC_BA98_7654_3005;
        key_max = 64'hFFFF_FFFF_FFFF_FFFF;
        key_top = 64'h8000_0000_0000_0000;

        // miss answer, and the answer of a store that wrote (other fields at miss values)
        miss_rsp  = mk_rsp(1'b0, '0, DEPTH_NONE, BOUND_ALL, '0);
        wrote_rsp = mk_rsp(1'b1, '0, DEPTH_NONE, BOUND_ALL, '0);

        // directed table: hand-written responses where obvious, predictor elsewhere
        // fresh table: probes miss, zero key is rejected
        add_row(mk_req(REQ_PROBE, key_a, '0, '0, BOUND_ALL, '0), 1, miss_rsp);
        add_row(mk_req(REQ_PROBE, '0, '0, '0, BOUND_ALL, '0), 1, miss_rsp);
        add_row(mk_req(REQ_STORE, '0, 8'sd127, 16'sd1, BOUND_PV, 32'h1), 1, miss_rsp);
        // empty slot takes any store
        add_row(mk_req(REQ_STORE, key_a, 8'sd5, 16'sh7FFF, BOUND_CUT, 32'hFFFF_FFFF),
                1, wrote_rsp);
        add_row(mk_req(REQ_PROBE, key_a, '0, '0, BOUND_ALL, '0), 1,
                mk_rsp(1'b1, 16'sh7FFF, 8'sd5, BOUND_CUT, 32'hFFFF_FFFF));
        // colliding key: equal depth loses, deeper wins
        add_row(mk_req(REQ_STORE, key_b, 8'sd5, 16'sd9, BOUND_ALL, 32'h9), 1, miss_rsp);
        add_row(mk_req(REQ_STORE, key_b, 8'sd6, 16'sh8000, BOUND_ALL, '0), 1, wrote_rsp);
        add_row(mk_req(REQ_PROBE, key_a, '0, '0, BOUND_ALL, '0), 1, miss_rsp);
        add_row(mk_req(REQ_PROBE, key_b, '0, '0, BOUND_ALL, '0), 1,
                mk_rsp(1'b1, 16'sh8000, 8'sd6, BOUND_ALL, '0));
        // exact bound replaces even at the shallowest depth
        add_row(mk_req(REQ_STORE, key_a, 8'sh80, 16'sd3, BOUND_PV, 32'h3), 1, wrote_rsp);
        // unused bound code does not force replacement
        add_row(mk_req(REQ_STORE, key_b, 8'sh80, 16'sd4, BOUND_BAD, 32'h4), 1, miss_rsp);
        // same key always replaces, unused bound kept as given
        add_row(mk_req(REQ_STORE, key_a, 8'sh80, 16'sh1234, BOUND_BAD, 32'hA5A5_A5A5),
                1, wrote_rsp);
        add_row(mk_req(REQ_PROBE, key_a, '0, '0, BOUND_ALL, '0), 1,
                mk_rsp(1'b1, 16'sh1234, 8'sh80, BOUND_BAD, 32'hA5A5_A5A5));
        // top slot and slot zero with a nonzero key
        add_row(mk_req(REQ_STORE, key_max, 8'sd127, 16'shFFFF, BOUND_PV, 32'h8000_0001),
                0, miss_rsp);
        add_row(mk_req(REQ_PROBE, key_max, '0, '0, BOUND_ALL, '0), 0, miss_rsp);
        add_row(mk_req(REQ_STORE, key_top, '0, 16'sd77, BOUND_CUT, 32'h5A5A_5A5A),
                0, miss_rsp);
        add_row(mk_req(REQ_PROBE, key_top, '0, '0, BOUND_ALL, '0), 0, miss_rsp);
        add_row(mk_req(REQ_PROBE, 64'h1, '0, '0, BOUND_ALL, '0), 1, miss_rsp);
        // unused request code with every field busy
        add_row(mk_req(REQ_UNUSED, key_max, 8'sd127, 16'sh7FFF, BOUND_PV, 32'hFFFF_FFFF),
                1, miss_rsp);
        add_row(mk_req(REQ_PROBE, key_max, '0, '0, BOUND_ALL, '0), 0, miss_rsp);
        // clear wipes everything
        add_row(mk_req(REQ_CLEAR, key_max, '0, '0, BOUND_ALL, '0), 1, wrote_rsp);
        add_row(mk_req(REQ_PROBE, key_max, '0, '0, BOUND_ALL, '0), 1, miss_rsp);
        add_row(mk_req(REQ_PROBE, key_a, '0, '0, BOUND_ALL, '0), 1, miss_rsp);
        add_row(mk_req(REQ_STORE, key_a, 8'sh80, '0, BOUND_ALL, '0), 1, wrote_rsp);
        add_row(mk_req(REQ_PROBE, key_a, '0, '0, BOUND_ALL, '0), 0, miss_rsp);

        // reset, then let the power-on sweep finish before touching the register
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        while (busy)
            @(posedge clk);

        // directed part with the empty move at its upper extreme
        write_empty_move(32'hFFFF_FFFF);
        foreach (dir_rows[i])
            send_req(dir_rows[i].rq, dir_rows[i].has_want, dir_rows[i].want);
        start <= 1'b0;
        drain();

        // random part, first with the empty move at zero, then a random value
        write_empty_move(32'h0);
        repeat (300)
            send_req(random_req(), 0, miss_rsp);
        start <= 1'b0;
        drain();

        write_empty_move($urandom);
        repeat (325)
            send_req(random_req(), 0, miss_rsp);
        start <= 1'b0;
        drain();

        $display("covered %0d transactions: %0d probe hits, %0d table writes,", n_req,
                 n_probe_hits, n_writes);
        $display("%0d full clears, %0d unused codes, %0d mismatches", n_clears, n_unused,
                 n_fail);
        if (n_fail == 0)
            $display("direct_mapped_search_table test passed");
        else
            $display("direct_mapped_search_table test failed");
        $finish;
    end

endmodule
